@@ design/antialiased_snake_activation_defines.svh @@
// Assertion macros shared by the checker.
`ifndef ANTIALIASED_SNAKE_ACTIVATION_DEFINES_SVH
`define ANTIALIASED_SNAKE_ACTIVATION_DEFINES_SVH

// Next-cycle implication, switched off while reset is held.
`define ASN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asn: check failed");

// Next-cycle implication that also holds across reset.
`define ASN_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("asn: check failed");

`endif

@@ design/asn_pkg.sv @@
package asn_pkg;

    localparam int TAPS_DEF        = 12;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SINE_DEPTH_DEF  = 1024;
    localparam int MAX_RESULTS     = 8;
    localparam int CFG_TAPS        = 12;   // taps that have a register
    localparam int TAPS_PER_REG    = 4;
    localparam int TAP_BITS        = 16;
    localparam int REG_BITS        = 64;
    localparam int CFG_IDX_BITS    = 3;
    localparam int ROUND_SHIFT     = 14;

    localparam logic [15:0] TWO_OVER_PI_Q16 = 16'd41722;
    localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
    localparam logic [15:0] ALPHA_RESET     = 16'd2048;
    localparam logic [15:0] INV_BETA_RESET  = 16'd2048;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_UP_LOW   = 3'd0,
        CFG_UP_MID   = 3'd1,
        CFG_UP_HIGH  = 3'd2,
        CFG_DN_LOW   = 3'd3,
        CFG_DN_MID   = 3'd4,
        CFG_DN_HIGH  = 3'd5,
        CFG_ALPHA    = 3'd6,
        CFG_INV_BETA = 3'd7
    } t_cfg_idx;

    // History control from the sequencer to the cell row.
    typedef struct packed {
        logic load;   // every cell takes the pushed sample
        logic shift;  // history moves one cell along
    } t_hist_ctl;

endpackage

@@ design/asn_cell.sv @@
module asn_cell #(
    parameter int TAPS        = asn_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = asn_pkg::SAMPLE_BITS_DEF,
    parameter int POS         = 0,
    parameter int AW          = 37
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  asn_pkg::t_hist_ctl                  i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]       i_load,
    input  logic signed [SAMPLE_BITS-1:0]       i_hist_prev,
    output logic signed [SAMPLE_BITS-1:0]       o_hist,
    input  logic signed [asn_pkg::TAP_BITS-1:0] i_taps [TAPS],
    input  logic signed [AW-1:0]                i_psum,
    input  logic [$clog2(TAPS)-1:0]             i_a,
    input  logic                                i_vld,
    output logic signed [AW-1:0]                o_psum,
    output logic [$clog2(TAPS)-1:0]             o_a,
    output logic                                o_vld
);
    import asn_pkg::*;

    localparam int IW = $clog2(TAPS);
    // Upsampled phase j of this cell meets tap 2j-1-a.
    localparam int FJ = 2 * (TAPS - 1 - POS) - 1;

    logic signed [SAMPLE_BITS-1:0]          r_hist;
    logic signed [AW-1:0]                   r_psum;
    logic [IW-1:0]                          r_a;
    logic                                   r_vld;
    logic signed [IW+2:0]                   w_f;
    logic                                   w_hit;
    logic signed [TAP_BITS-1:0]             w_tap;
    logic signed [TAP_BITS+SAMPLE_BITS-1:0] w_prod;
    logic signed [AW-1:0]                   w_term;

    assign w_f    = (IW+3)'(FJ) - $signed({3'b000, i_a});
    assign w_hit  = (w_f >= 0) && (w_f < TAPS);
    assign w_tap  = w_hit ? i_taps[w_f[IW-1:0]] : '0;
    assign w_prod = w_tap * r_hist;
    assign w_term = AW'(w_prod) <<< 1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_hist <= i_load;
        end else if (i_ctl.shift) begin
            r_hist <= i_hist_prev;
        end
        r_psum <= i_psum + w_term;
        r_a    <= i_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    assign o_hist = r_hist;
    assign o_psum = r_psum;
    assign o_a    = r_a;
    assign o_vld  = r_vld;

endmodule

@@ design/asn_snake.sv @@
module asn_snake #(
    parameter int TAPS             = asn_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS      = asn_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = asn_pkg::SINE_DEPTH_DEF,
    parameter int AW               = 37
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [15:0]                   i_alpha,
    input  logic [15:0]                   i_inv_beta,
    input  logic signed [AW-1:0]          i_psum,
    input  logic [$clog2(TAPS)-1:0]       i_a,
    input  logic                          i_vld,
    output logic signed [SAMPLE_BITS+3:0] o_y,
    output logic [$clog2(TAPS)-1:0]       o_a,
    output logic                          o_vld
);
    import asn_pkg::*;

    localparam int IW     = $clog2(TAPS);
    localparam int WB     = SAMPLE_BITS + 4;
    localparam int FRAC   = SAMPLE_BITS - 4;
    localparam int D      = $clog2(SINE_TABLE_DEPTH);
    localparam int SH     = 8 + FRAC + 19 - D;
    localparam int STAGES = 8;
    localparam int PW     = 49;

    localparam logic signed [AW:0] V_HI = (AW+1)'((64'sd1 <<< (WB - 1)) - 64'sd1);
    localparam logic signed [AW:0] V_LO = -V_HI - 1;
    localparam logic signed [PW:0] Y_HI = (PW+1)'((64'sd1 <<< (WB - 1)) - 64'sd1);
    localparam logic signed [PW:0] Y_LO = -Y_HI - 1;

    localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210, 64'd272};

    typedef logic [15:0] t_rom [0:SINE_TABLE_DEPTH];

    // Quarter-wave sine in Q1.15 by a nine-term Taylor series in Q30.
    function automatic t_rom build_sine();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = 64'(i) * HALF_PI_Q30 / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k];
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 16384) >>> 15;
            rom[i] = (sum > 32768) ? 16'd32768 : 16'(sum);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_sine();

    logic signed [WB-1:0] r_v   [1:STAGES-1];
    logic [IW-1:0]        r_a   [1:STAGES];
    logic                 r_vld [1:STAGES];

    logic [WB+15:0]       r_m1;
    logic [WB+31:0]       r_m2;
    logic [D:0]           r_addr;
    logic [15:0]          r_s;
    logic [31:0]          r_ss;
    logic [47:0]          r_pb;
    logic signed [WB-1:0] r_y;

    logic signed [AW:0]   w_sh;
    logic signed [WB-1:0] w_v;
    logic [WB-1:0]        w_mag;
    logic [D:0]           w_r;
    logic [D+1:0]         w_fold;
    logic [PW-1:0]        w_add;
    logic signed [PW:0]   w_ysum;
    logic signed [WB-1:0] w_y;

    always_comb begin
        w_sh = (AW+1)'(i_psum) + (AW+1)'(1 <<< (ROUND_SHIFT - 1));
        w_sh = w_sh >>> ROUND_SHIFT;
        if (w_sh > V_HI) begin
            w_v = WB'(V_HI);
        end else if (w_sh < V_LO) begin
            w_v = WB'(V_LO);
        end else begin
            w_v = WB'(w_sh);
        end
    end

    assign w_mag  = r_v[1][WB-1] ? WB'(-r_v[1]) : WB'(r_v[1]);
    // sin^2 has period pi: keep two quarter turns and mirror the second.
    assign w_r    = r_m2[SH+D:SH];
    assign w_fold = w_r[D] ? ((D+2)'(2 * SINE_TABLE_DEPTH) - (D+2)'(w_r)) : (D+2)'(w_r);

    always_comb begin
        w_add  = (PW'(r_pb) + (PW'(1) << (40 - FRAC))) >> (41 - FRAC);
        w_ysum = $signed({1'b0, w_add}) + (PW+1)'(r_v[STAGES-1]);
        if (w_ysum > Y_HI) begin
            w_y = WB'(Y_HI);
        end else if (w_ysum < Y_LO) begin
            w_y = WB'(Y_LO);
        end else begin
            w_y = WB'(w_ysum);
        end
    end

    always_ff @(posedge i_clk) begin
        r_v[1] <= w_v;
        for (int s = 2; s < STAGES; s++) begin
            r_v[s] <= r_v[s-1];
        end
        r_a[1] <= i_a;
        for (int s = 2; s <= STAGES; s++) begin
            r_a[s] <= r_a[s-1];
        end
        r_m1   <= w_mag * i_alpha;
        r_m2   <= r_m1 * TWO_OVER_PI_Q16;
        r_addr <= w_fold[D:0];
        r_s    <= SINE_ROM[r_addr];
        r_ss   <= r_s * r_s;
        r_pb   <= r_ss * i_inv_beta;
        r_y    <= w_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[1] <= i_vld;
            for (int s = 2; s <= STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign o_y   = r_y;
    assign o_a   = r_a[STAGES];
    assign o_vld = r_vld[STAGES];

endmodule

@@ design/asn_seq.sv @@
module asn_seq #(
    parameter int TAPS        = asn_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = asn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_first,
    input  logic                          i_last,
    input  logic                          i_room,
    input  logic                          i_done,
    output asn_pkg::t_hist_ctl            o_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_push,
    output logic                          o_iss_vld,
    output logic [$clog2(TAPS)-1:0]       o_iss_a,
    output logic                          o_end
);
    import asn_pkg::*;

    localparam int HALF = TAPS / 2;
    localparam int IW   = $clog2(TAPS);
    localparam int FW   = $clog2(HALF + 1);
    localparam int LW   = $clog2(HALF);
    localparam int OW   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [FW-1:0]                 r_fill, n_fill;
    logic signed [SAMPLE_BITS-1:0] r_edge, n_edge;
    logic                          r_last, n_last;
    logic [LW-1:0]                 r_left, n_left;
    logic [OW-1:0]                 r_ocnt, n_ocnt;
    logic [IW-1:0]                 r_a, n_a;
    logic                          r_end, n_end;

    logic                          w_accept;
    logic                          w_restart;
    logic [FW-1:0]                 w_inc;

    assign o_ready   = (r_state == ST_IDLE) && i_room;
    assign w_accept  = o_ready && i_valid;
    assign w_restart = i_first || (r_fill == '0);
    assign w_inc     = (r_fill < FW'(HALF)) ? r_fill + 1'b1 : r_fill;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_edge      = r_edge;
        n_last      = r_last;
        n_left      = r_left;
        n_ocnt      = r_ocnt;
        n_a         = r_a;
        n_end       = r_end;
        o_ctl.load  = 1'b0;
        o_ctl.shift = 1'b0;
        o_push      = w_accept ? i_sample : r_edge;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_ctl.load  = w_restart;
                    o_ctl.shift = !w_restart;
                    n_fill      = w_restart ? FW'(1) : w_inc;
                    n_edge      = i_sample;
                    n_last      = i_last;
                    n_left      = LW'(HALF - 1);
                    n_ocnt      = '0;
                    n_a         = '0;
                    n_end       = i_last && ((HALF == 1) || (MAX_RESULTS == 1));
                    if (n_fill >= FW'(HALF)) begin
                        n_state = ST_ISSUE;
                    end else if (i_last) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_ISSUE: begin
                n_a = r_a + 1'b1;
                if (r_a == IW'(TAPS - 1)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_done) begin
                    n_ocnt = r_ocnt + 1'b1;
                    if (!r_last) begin
                        n_state = ST_IDLE;
                    end else if (r_left == '0 || n_ocnt == OW'(MAX_RESULTS)) begin
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_room) begin
                    o_ctl.shift = 1'b1;
                    n_fill      = w_inc;
                    n_left      = r_left - 1'b1;
                    n_a         = '0;
                    n_end       = (n_left == '0) || (r_ocnt == OW'(MAX_RESULTS - 1));
                    if (n_fill >= FW'(HALF)) begin
                        n_state = ST_ISSUE;
                    end else if (n_left == '0) begin
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_last  <= 1'b0;
            r_left  <= '0;
            r_ocnt  <= '0;
            r_a     <= '0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_last  <= n_last;
            r_left  <= n_left;
            r_ocnt  <= n_ocnt;
            r_a     <= n_a;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge <= n_edge;
    end

    assign o_iss_vld = (r_state == ST_ISSUE);
    assign o_iss_a   = r_a;
    assign o_end     = r_end;

endmodule

@@ design/antialiased_snake_activation.sv @@
// Alias-free snake activation for one channel of audio samples.
// Samples arrive as words on the s_axis channel: tdata carries the signed
// sample, tuser marks the first sample of a run and tlast the last one.
// Results leave on m_axis, one word per input sample, with tlast set on
// the final word of a run. A last sample also drives TAPS/2-1 replicated
// edge samples through the filters to flush the run.
// Each sample pushed into the history issues its TAPS upsampled phases
// into the row of cells; they pass through the row and the snake pipeline,
// and the down filter sums them into a word for the output queue.
// The walk through the cell row and the single shared snake unit set the
// rate; one sample is worked on at a time. Before a run has filled TAPS/2
// samples a push produces no word and is not issued into the cell row.
// Reset clears the control state, sets the taps to zero and alpha and
// 1/beta to one; no clearing pass is needed.
// A two-word output queue parts the two sides: a stalled receiver fills it
// and s_axis_tready then stays low until a word is taken.
// Configuration must be written only while the block is idle; the block does not enforce this.
module antialiased_snake_activation #(
    parameter int TAPS             = asn_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS      = asn_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = asn_pkg::SINE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [asn_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [asn_pkg::REG_BITS-1:0]        i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample, zero-filled to whole bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // first
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // result, zero-filled to whole bytes
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);
    import asn_pkg::*;

    localparam int IW  = $clog2(TAPS);
    localparam int WB  = SAMPLE_BITS + 4;
    localparam int AW  = SAMPLE_BITS + TAP_BITS + 1 + $clog2(TAPS);
    localparam int PDW = WB + TAP_BITS;
    localparam int DAW = PDW + $clog2(TAPS);
    localparam int DW  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int NREG_TAPS = 6;

    localparam logic signed [DAW:0] O_HI =
        (DAW+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [DAW:0] O_LO = -O_HI - 1;

    // Configuration registers.
    logic [REG_BITS-1:0] r_taps [NREG_TAPS];
    logic [15:0]         r_alpha;
    logic [15:0]         r_inv_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NREG_TAPS; r++) begin
                r_taps[r] <= '0;
            end
            r_alpha    <= ALPHA_RESET;
            r_inv_beta <= INV_BETA_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_UP_LOW:   r_taps[0]  <= i_cfg_data;
                CFG_UP_MID:   r_taps[1]  <= i_cfg_data;
                CFG_UP_HIGH:  r_taps[2]  <= i_cfg_data;
                CFG_DN_LOW:   r_taps[3]  <= i_cfg_data;
                CFG_DN_MID:   r_taps[4]  <= i_cfg_data;
                CFG_DN_HIGH:  r_taps[5]  <= i_cfg_data;
                CFG_ALPHA:    r_alpha    <= i_cfg_data[15:0];
                CFG_INV_BETA: r_inv_beta <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Taps beyond those held in registers read as zero.
    logic signed [TAP_BITS-1:0] w_up [TAPS];
    logic signed [TAP_BITS-1:0] w_dn [TAPS];

    for (genvar f = 0; f < TAPS; f++) begin : g_taps
        if (f < CFG_TAPS) begin : g_reg
            assign w_up[f] = r_taps[f / TAPS_PER_REG][TAP_BITS*(f % TAPS_PER_REG) +: TAP_BITS];
            assign w_dn[f] = r_taps[f / TAPS_PER_REG + 3][TAP_BITS*(f % TAPS_PER_REG) +: TAP_BITS];
        end else begin : g_zero
            assign w_up[f] = '0;
            assign w_dn[f] = '0;
        end
    end

    // Sequencer.
    t_hist_ctl                     w_ctl;
    logic signed [SAMPLE_BITS-1:0] w_push;
    logic                          w_iss_vld;
    logic [IW-1:0]                 w_iss_a;
    logic                          w_end;
    logic                          w_room;
    logic                          r_done;

    asn_seq #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_first   (s_axis_tuser[0]),
        .i_last    (s_axis_tlast),
        .i_room    (w_room),
        .i_done    (r_done),
        .o_ctl     (w_ctl),
        .o_push    (w_push),
        .o_iss_vld (w_iss_vld),
        .o_iss_a   (w_iss_a),
        .o_end     (w_end)
    );

    // Row of cells: each holds one history sample and adds its product to
    // the partial sum of the upsampled phase passing through.
    logic signed [SAMPLE_BITS-1:0] w_hist [TAPS+1];
    logic signed [AW-1:0]          w_psum [TAPS+1];
    logic [IW-1:0]                 w_a    [TAPS+1];
    logic                          w_vld  [TAPS+1];

    assign w_hist[0] = w_push;
    assign w_psum[0] = '0;
    assign w_a[0]    = w_iss_a;
    assign w_vld[0]  = w_iss_vld;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        asn_cell #(
            .TAPS        (TAPS),
            .SAMPLE_BITS (SAMPLE_BITS),
            .POS         (k),
            .AW          (AW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_load      (w_push),
            .i_hist_prev (w_hist[k]),
            .o_hist      (w_hist[k+1]),
            .i_taps      (w_up),
            .i_psum      (w_psum[k]),
            .i_a         (w_a[k]),
            .i_vld       (w_vld[k]),
            .o_psum      (w_psum[k+1]),
            .o_a         (w_a[k+1]),
            .o_vld       (w_vld[k+1])
        );
    end

    // Snake activation of each upsampled phase.
    logic signed [WB-1:0] w_y;
    logic [IW-1:0]        w_y_a;
    logic                 w_y_vld;

    asn_snake #(
        .TAPS             (TAPS),
        .SAMPLE_BITS      (SAMPLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .AW               (AW)
    ) u_snake (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_alpha    (r_alpha),
        .i_inv_beta (r_inv_beta),
        .i_psum     (w_psum[TAPS]),
        .i_a        (w_a[TAPS]),
        .i_vld      (w_vld[TAPS]),
        .o_y        (w_y),
        .o_a        (w_y_a),
        .o_vld      (w_y_vld)
    );

    // Down filter: one product a cycle into an accumulator; phase zero
    // opens a new sum and the last phase closes it.
    logic signed [PDW-1:0] r_prod;
    logic [IW-1:0]         r_prod_a;
    logic                  r_prod_vld;
    logic signed [DAW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        r_prod   <= w_y * w_dn[w_y_a];
        r_prod_a <= w_y_a;
        if (r_prod_vld) begin
            r_acc <= ((r_prod_a == '0) ? '0 : r_acc) + DAW'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_prod_vld <= w_y_vld;
            r_done     <= r_prod_vld && (r_prod_a == IW'(TAPS - 1));
        end
    end

    logic signed [DAW:0]           w_osh;
    logic signed [SAMPLE_BITS-1:0] w_out;

    always_comb begin
        w_osh = (DAW+1)'(r_acc) + (DAW+1)'(1 <<< (ROUND_SHIFT - 1));
        w_osh = w_osh >>> ROUND_SHIFT;
        if (w_osh > O_HI) begin
            w_out = SAMPLE_BITS'(O_HI);
        end else if (w_osh < O_LO) begin
            w_out = SAMPLE_BITS'(O_LO);
        end else begin
            w_out = SAMPLE_BITS'(w_osh);
        end
    end

    // Two-word output queue.
    logic [SAMPLE_BITS-1:0] r_q_data [2];
    logic                   r_q_end  [2];
    logic                   r_q_wr;
    logic                   r_q_rd;
    logic [1:0]             r_q_cnt;
    logic                   w_q_pop;

    assign w_room  = (r_q_cnt != 2'd2);
    assign w_q_pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (r_done) begin
            r_q_data[r_q_wr] <= w_out;
            r_q_end[r_q_wr]  <= w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= 1'b0;
            r_q_rd  <= 1'b0;
            r_q_cnt <= 2'd0;
        end else begin
            if (r_done) begin
                r_q_wr <= !r_q_wr;
            end
            if (w_q_pop) begin
                r_q_rd <= !r_q_rd;
            end
            r_q_cnt <= r_q_cnt + {1'b0, r_done} - {1'b0, w_q_pop};
        end
    end

    assign m_axis_tvalid = (r_q_cnt != 2'd0);
    assign m_axis_tdata  = DW'(r_q_data[r_q_rd]);
    assign m_axis_tlast  = r_q_end[r_q_rd];

endmodule

@@ design/asn_checker.sv @@
`include "antialiased_snake_activation_defines.svh"

module asn_checker #(
    parameter int DW = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          s_axis_tlast,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [DW-1:0] m_axis_tdata,
    input logic          m_axis_tlast
);

    // A word waiting on a stalled receiver stays put.
    `ASN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Nothing is offered in the cycle after reset.
    `ASN_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)

    // The last sample of a run always takes the block out of idle, into issue or flush, so input closes.
    `ASN_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

endmodule

bind antialiased_snake_activation asn_checker #(
    .DW ($bits(m_axis_tdata))
) u_asn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
